/* rtl/hbd_pkg.sv */
// Package for the HTTP body dechunker: item types, phase and outcome codes,
// character constants and the hex digit decoder.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package hbd_pkg;

  // Field widths fixed by the item format
  localparam int LengthBits = 40;
  localparam int ChunkBits  = 32;

  // Command queue between front and back
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  // Characters of the chunked syntax
  localparam logic [7:0] CHAR_SEMI = 8'h3B;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;

  // Opcodes
  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_INCOMPLETE = 2'd0;
  localparam logic [1:0] ST_COMPLETE   = 2'd1;
  localparam logic [1:0] ST_ERROR      = 2'd2;

  // Error kinds
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_BAD     = 2'd1;
  localparam logic [1:0] ERR_NOTIMPL = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_COMPLETE   = 4'd1,
    PH_ERROR      = 4'd2,
    PH_IDENTITY   = 4'd3,
    PH_SIZE       = 4'd4,
    PH_SIZE_LF    = 4'd5,
    PH_EXT        = 4'd6,
    PH_EXT_LF     = 4'd7,
    PH_DATA       = 4'd8,
    PH_DATA_CR    = 4'd9,
    PH_DATA_LF    = 4'd10,
    PH_TRAILER    = 4'd11,
    PH_TRAILER_LF = 4'd12
  } phase_t;

  // Decision taken from the header facts of a begin item
  typedef enum logic [2:0] {
    OC_BAD      = 3'd0,
    OC_NOTIMPL  = 3'd1,
    OC_COMPLETE = 3'd2,
    OC_IDENTITY = 3'd3,
    OC_CHUNKED  = 3'd4
  } outcome_t;

  typedef struct packed {
    logic                  opcode;
    logic                  has_transfer_encoding;
    logic                  encoding_is_chunked;
    logic                  has_content_length;
    logic                  length_is_valid;
    logic [LengthBits-1:0] content_length;
    logic [7:0]            data_byte;
  } in_item_t;

  typedef struct packed {
    logic       body_valid;
    logic [7:0] body_byte;
    logic [1:0] parse_status;
    logic [1:0] error_kind;
  } out_item_t;

  // Classified item as it travels through the queue
  typedef struct packed {
    logic                  is_begin;
    outcome_t              outcome;
    logic [LengthBits-1:0] length;
    logic [7:0]            data_byte;
    logic                  is_hex;
    logic [3:0]            hex_val;
    logic                  is_semi;
    logic                  is_cr;
    logic                  is_lf;
  } cmd_t;

  // Hex digit value; bit 4 flags a valid digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/hbd_front.sv */
// Front end of the dechunker: accepts input items, decides the begin outcome
// and classifies data bytes into a command for the queue.
// Depends on hbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hbd_front
  import hbd_pkg::*;
(
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  input  wire logic     q_full,
  output logic          q_push,
  output cmd_t          q_cmd
);

  logic [4:0] hex;

  // Stall only while the queue has no room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign hex      = hex_decode(in_item.data_byte);

  // Classify the item
  always_comb begin
    q_cmd           = '0;
    q_cmd.is_begin  = (in_item.opcode == OP_BEGIN);
    q_cmd.length    = in_item.content_length;
    q_cmd.data_byte = in_item.data_byte;
    q_cmd.is_hex    = hex[4];
    q_cmd.hex_val   = hex[3:0];
    q_cmd.is_semi   = (in_item.data_byte == CHAR_SEMI);
    q_cmd.is_cr     = (in_item.data_byte == CHAR_CR);
    q_cmd.is_lf     = (in_item.data_byte == CHAR_LF);
    if (in_item.has_transfer_encoding) begin
      if (!in_item.encoding_is_chunked) begin
        q_cmd.outcome = OC_NOTIMPL;
      end else if (in_item.has_content_length) begin
        q_cmd.outcome = OC_BAD;
      end else begin
        q_cmd.outcome = OC_CHUNKED;
      end
    end else if (in_item.has_content_length) begin
      if (!in_item.length_is_valid) begin
        q_cmd.outcome = OC_BAD;
      end else if (in_item.content_length == '0) begin
        q_cmd.outcome = OC_COMPLETE;
      end else begin
        q_cmd.outcome = OC_IDENTITY;
      end
    end else begin
      q_cmd.outcome = OC_COMPLETE;
    end
  end

endmodule

`default_nettype wire

/* rtl/hbd_queue.sv */
// Short command queue between the front and back of the dechunker.
// Depends on hbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hbd_queue
  import hbd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output logic      full,
  output logic      empty,
  output cmd_t      head
);

  cmd_t           mem_r [QDepth];
  logic [QAw-1:0] wr_ptr_r;
  logic [QAw-1:0] rd_ptr_r;
  logic [QAw:0]   count_r;

  assign full  = (count_r == (QAw+1)'(QDepth));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/hbd_back.sv */
// Back end of the dechunker: runs the body parsing state machine on queued
// commands and holds the result item in an output register.
// Depends on hbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hbd_back
  import hbd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_empty,
  input  wire cmd_t q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_item_t out_item
);

  phase_t                phase_r, phase_nxt;
  logic [LengthBits-1:0] bytes_left_r, bytes_left_nxt;
  logic [ChunkBits-1:0]  size_acc_r, size_acc_nxt;
  logic                  digit_seen_r, digit_seen_nxt;
  logic                  line_empty_r, line_empty_nxt;
  logic [1:0]            sticky_r, sticky_nxt;
  logic                  out_valid_r;
  out_item_t             out_r, out_nxt;
  logic                  body_valid;

  // Take a command whenever the output register is free or being drained
  assign q_pop     = !q_empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Next state for one command
  always_comb begin
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    size_acc_nxt   = size_acc_r;
    digit_seen_nxt = digit_seen_r;
    line_empty_nxt = line_empty_r;
    sticky_nxt     = sticky_r;
    body_valid     = 1'b0;
    if (q_head.is_begin) begin
      phase_nxt      = PH_IDLE;
      bytes_left_nxt = '0;
      size_acc_nxt   = '0;
      digit_seen_nxt = 1'b0;
      line_empty_nxt = 1'b1;
      sticky_nxt     = ERR_NONE;
      case (q_head.outcome)
        OC_BAD: begin
          phase_nxt  = PH_ERROR;
          sticky_nxt = ERR_BAD;
        end
        OC_NOTIMPL: begin
          phase_nxt  = PH_ERROR;
          sticky_nxt = ERR_NOTIMPL;
        end
        OC_COMPLETE: begin
          phase_nxt = PH_COMPLETE;
        end
        OC_IDENTITY: begin
          phase_nxt      = PH_IDENTITY;
          bytes_left_nxt = q_head.length;
        end
        OC_CHUNKED: begin
          phase_nxt = PH_SIZE;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end else begin
      case (phase_r)
        PH_IDENTITY: begin
          body_valid     = 1'b1;
          bytes_left_nxt = bytes_left_r - 1'b1;
          if (bytes_left_r == LengthBits'(1)) begin
            phase_nxt = PH_COMPLETE;
          end
        end
        PH_SIZE: begin
          if (q_head.is_hex) begin
            if (size_acc_r[ChunkBits-1 -: 4] != 4'd0) begin
              phase_nxt  = PH_ERROR;
              sticky_nxt = ERR_BAD;
            end else begin
              size_acc_nxt   = {size_acc_r[ChunkBits-5:0], q_head.hex_val};
              digit_seen_nxt = 1'b1;
            end
          end else if (q_head.is_semi) begin
            phase_nxt = PH_EXT;
          end else if (q_head.is_cr) begin
            phase_nxt = PH_SIZE_LF;
          end else begin
            phase_nxt  = PH_ERROR;
            sticky_nxt = ERR_BAD;
          end
        end
        PH_SIZE_LF, PH_EXT_LF: begin
          if (q_head.is_lf) begin
            // end of size line
            if (!digit_seen_r) begin
              phase_nxt  = PH_ERROR;
              sticky_nxt = ERR_BAD;
            end else if (size_acc_r == '0) begin
              phase_nxt      = PH_TRAILER;
              line_empty_nxt = 1'b1;
            end else begin
              phase_nxt = PH_DATA;
            end
          end else if (phase_r == PH_SIZE_LF) begin
            phase_nxt  = PH_ERROR;
            sticky_nxt = ERR_BAD;
          end else if (!q_head.is_cr) begin
            phase_nxt = PH_EXT;
          end
        end
        PH_EXT: begin
          if (q_head.is_cr) begin
            phase_nxt = PH_EXT_LF;
          end
        end
        PH_DATA: begin
          body_valid   = 1'b1;
          size_acc_nxt = size_acc_r - 1'b1;
          if (size_acc_r == ChunkBits'(1)) begin
            phase_nxt = PH_DATA_CR;
          end
        end
        PH_DATA_CR: begin
          if (q_head.is_cr) begin
            phase_nxt = PH_DATA_LF;
          end else begin
            phase_nxt  = PH_ERROR;
            sticky_nxt = ERR_BAD;
          end
        end
        PH_DATA_LF: begin
          if (q_head.is_lf) begin
            phase_nxt      = PH_SIZE;
            size_acc_nxt   = '0;
            digit_seen_nxt = 1'b0;
          end else begin
            phase_nxt  = PH_ERROR;
            sticky_nxt = ERR_BAD;
          end
        end
        PH_TRAILER: begin
          if (q_head.is_cr) begin
            phase_nxt = PH_TRAILER_LF;
          end else begin
            line_empty_nxt = 1'b0;
          end
        end
        PH_TRAILER_LF: begin
          if (q_head.is_lf) begin
            if (line_empty_r) begin
              phase_nxt = PH_COMPLETE;
            end else begin
              line_empty_nxt = 1'b1;
              phase_nxt      = PH_TRAILER;
            end
          end else begin
            line_empty_nxt = 1'b0;
            if (!q_head.is_cr) begin
              phase_nxt = PH_TRAILER;
            end
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // Build the result from the state left behind
  always_comb begin
    out_nxt            = '0;
    out_nxt.body_valid = body_valid;
    out_nxt.body_byte  = body_valid ? q_head.data_byte : 8'd0;
    case (phase_nxt)
      PH_COMPLETE: out_nxt.parse_status = ST_COMPLETE;
      PH_ERROR: begin
        out_nxt.parse_status = ST_ERROR;
        out_nxt.error_kind   = sticky_nxt;
      end
      default: out_nxt.parse_status = ST_INCOMPLETE;
    endcase
  end

  // Parser state advances on each popped command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bytes_left_r <= '0;
      size_acc_r   <= '0;
      digit_seen_r <= 1'b0;
      line_empty_r <= 1'b1;
      sticky_r     <= ERR_NONE;
    end else if (q_pop) begin
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      size_acc_r   <= size_acc_nxt;
      digit_seen_r <= digit_seen_nxt;
      line_empty_r <= line_empty_nxt;
      sticky_r     <= sticky_nxt;
    end
  end

  // Output register: load on pop, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r <= out_nxt;
    end
  end

  a_err_kind_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.parse_status == ST_ERROR |-> out_r.error_kind != ERR_NONE)
    else $error("error result without an error kind");

  a_err_kind_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.parse_status != ST_ERROR |-> out_r.error_kind == ERR_NONE)
    else $error("error kind reported without error status");

  a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> size_acc_r != '0)
    else $error("chunk data phase with nothing left");

  a_identity_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDENTITY |-> bytes_left_r != '0)
    else $error("identity phase with nothing left");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ERROR |-> sticky_r != ERR_NONE)
    else $error("error phase without a recorded error");

endmodule

`default_nettype wire

/* rtl/http_body_dechunker.sv */
// Byte-serial HTTP request body decoder: takes one item per cycle unless stalled,
// a begin item with header facts or one received body byte, and returns one
// result item for each, in order. An accepted item enters a four-entry command
// queue between the classifying front and the parsing back, and its result is
// registered in the back's output register; the queue absorbs stalls on the
// result side, and the input stalls only when that queue is full. The rate is
// set by the back end's per-byte state update, one byte per cycle unless stalled.
// Depends on hbd_pkg, hbd_front, hbd_queue and hbd_back.
`timescale 1ns / 1ps
`default_nettype none

module http_body_dechunker
  import hbd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_item
);

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t q_cmd;
  cmd_t q_head;

  hbd_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  hbd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  hbd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

/* tb/sv/http_body_dechunker_tb.sv */
// Self-checking testbench for http_body_dechunker: a directed table, then random
// chunked, identity and malformed bodies; results checked against the table or a predictor.
// Depends on hbd_pkg and the http_body_dechunker RTL.
`timescale 1ns / 1ps

module http_body_dechunker_tb;
  import hbd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1650;
  localparam int DRAIN_CYCLES = 8;

  // Header fact bits: {transfer-encoding, chunked, content-length, length valid}
  localparam logic [3:0] HDR_NONE       = 4'b0000;
  localparam logic [3:0] HDR_OTHER_TE   = 4'b1000;
  localparam logic [3:0] HDR_CHUNKED    = 4'b1100;
  localparam logic [3:0] HDR_CHUNKED_CL = 4'b1110;
  localparam logic [3:0] HDR_BAD_LEN    = 4'b0010;
  localparam logic [3:0] HDR_LEN        = 4'b0011;
  localparam logic [3:0] HDR_ALL        = 4'b1111;

  localparam logic [LengthBits-1:0] NOLEN  = '0;
  localparam logic [LengthBits-1:0] MAXLEN = '1;

  localparam out_item_t OUT_ANY  = '0;
  localparam out_item_t OUT_BUSY = '{1'b0, 8'h00, ST_INCOMPLETE, ERR_NONE};
  localparam out_item_t OUT_NUL  = '{1'b1, 8'h00, ST_INCOMPLETE, ERR_NONE};
  localparam out_item_t OUT_DONE = '{1'b0, 8'h00, ST_COMPLETE, ERR_NONE};
  localparam out_item_t OUT_BAD  = '{1'b0, 8'h00, ST_ERROR, ERR_BAD};
  localparam out_item_t OUT_NI   = '{1'b0, 8'h00, ST_ERROR, ERR_NOTIMPL};

  typedef struct packed {
    logic                  typed;
    out_item_t             want;
    logic                  op;
    logic [3:0]            hdr;
    logic [LengthBits-1:0] len;
    logic [7:0]            b;
  } plan_row_t;

  typedef struct packed {
    logic      typed;
    out_item_t want;
  } hint_t;

  localparam int PLAN_ROWS = 57;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // data before any begin, outcomes of the header facts, sticky error
    '{1'b1, OUT_BUSY, OP_DATA,  HDR_NONE,       NOLEN,  8'hFF},
    '{1'b1, OUT_NI,   OP_BEGIN, HDR_OTHER_TE,   NOLEN,  8'h00},
    '{1'b1, OUT_NI,   OP_DATA,  HDR_NONE,       NOLEN,  CHAR_CR},
    '{1'b1, OUT_BAD,  OP_BEGIN, HDR_CHUNKED_CL, NOLEN,  8'h00},
    '{1'b1, OUT_BAD,  OP_BEGIN, HDR_BAD_LEN,    MAXLEN, 8'h00},
    '{1'b1, OUT_DONE, OP_BEGIN, HDR_NONE,       MAXLEN, 8'hFF},
    '{1'b1, OUT_DONE, OP_BEGIN, HDR_LEN,        NOLEN,  8'h00},
    '{1'b1, OUT_DONE, OP_DATA,  HDR_NONE,       NOLEN,  "0"},
    // identity counting: largest length, then a short one run to the end
    '{1'b1, OUT_BUSY, OP_BEGIN, HDR_LEN,        MAXLEN, 8'h00},
    '{1'b1, OUT_NUL,  OP_DATA,  HDR_NONE,       NOLEN,  8'h00},
    '{1'b1, OUT_BUSY, OP_BEGIN, HDR_LEN,        40'd2,  8'h00},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  8'hA5},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_ALL,        MAXLEN, 8'h5A},
    // chunked: extension with a lone CR, one chunk, trailer with a lone CR
    '{1'b1, OUT_BUSY, OP_BEGIN, HDR_CHUNKED,    NOLEN,  8'h00},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  "1"},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  CHAR_SEMI},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  CHAR_CR},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  "x"},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  CHAR_CR},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  CHAR_LF},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  8'hFF},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  CHAR_CR},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  CHAR_LF},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  "0"},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  CHAR_CR},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  CHAR_LF},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  "T"},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  CHAR_CR},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  CHAR_CR},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  CHAR_LF},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  CHAR_CR},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  CHAR_LF},
    // bad byte in the size part
    '{1'b1, OUT_BUSY, OP_BEGIN, HDR_CHUNKED,    NOLEN,  8'h00},
    '{1'b1, OUT_BAD,  OP_DATA,  HDR_NONE,       NOLEN,  "g"},
    // empty size line
    '{1'b1, OUT_BUSY, OP_BEGIN, HDR_CHUNKED,    NOLEN,  8'h00},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  CHAR_CR},
    '{1'b1, OUT_BAD,  OP_DATA,  HDR_NONE,       NOLEN,  CHAR_LF},
    // size overflow on the ninth digit
    '{1'b1, OUT_BUSY, OP_BEGIN, HDR_CHUNKED,    NOLEN,  8'h00},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  "f"},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  "F"},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  "f"},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  "F"},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  "f"},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  "F"},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  "f"},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  "F"},
    '{1'b1, OUT_BAD,  OP_DATA,  HDR_NONE,       NOLEN,  "a"},
    // CR in the size part without LF
    '{1'b1, OUT_BUSY, OP_BEGIN, HDR_CHUNKED,    NOLEN,  8'h00},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  "A"},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  CHAR_CR},
    '{1'b1, OUT_BAD,  OP_DATA,  HDR_NONE,       NOLEN,  "x"},
    // missing CR LF after the chunk data
    '{1'b1, OUT_BUSY, OP_BEGIN, HDR_CHUNKED,    NOLEN,  8'h00},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  "1"},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  CHAR_CR},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  CHAR_LF},
    '{1'b0, OUT_ANY,  OP_DATA,  HDR_NONE,       NOLEN,  8'h00},
    '{1'b1, OUT_BAD,  OP_DATA,  HDR_NONE,       NOLEN,  "z"}
  };

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  int  cycles = 0;
  int  mismatches = 0;
  int  generated = 0;
  logic calm;

  in_item_t  stim_q[$];
  hint_t     hint_q[$];
  out_item_t decoded_q[$];
  logic [7:0] body_text[$];

  // Decoder state as the predictor sees it
  phase_t                dec_phase = PH_IDLE;
  logic [LengthBits-1:0] dec_left = '0;
  logic [ChunkBits-1:0]  dec_size = '0;
  logic                  dec_digit = 1'b0;
  logic                  dec_empty = 1'b1;
  logic [1:0]            dec_error = ERR_NONE;

  http_body_dechunker dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // One stretch with no idling on either side
  assign calm = (cycles >= 1000 && cycles < 1600);

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 14);
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic void raise_error(input logic [1:0] kind);
    dec_phase = PH_ERROR;
    dec_error = kind;
  endfunction

  // Advance the decoder state by one item and return the result it gives
  function automatic out_item_t decode_item(input in_item_t it);
    out_item_t  r;
    logic       payload;
    logic       line_done;
    logic [4:0] hx;
    logic [7:0] c;
    payload   = 1'b0;
    line_done = 1'b0;
    c         = it.data_byte;
    hx        = 5'd0;
    if (c >= "0" && c <= "9") begin
      hx = {1'b1, 4'(c - "0")};
    end else if (c >= "a" && c <= "f") begin
      hx = {1'b1, 4'(c - "a" + 8'd10)};
    end else if (c >= "A" && c <= "F") begin
      hx = {1'b1, 4'(c - "A" + 8'd10)};
    end

    if (it.opcode == OP_BEGIN) begin
      dec_phase = PH_IDLE;
      dec_left  = '0;
      dec_size  = '0;
      dec_digit = 1'b0;
      dec_empty = 1'b1;
      dec_error = ERR_NONE;
      if (it.has_transfer_encoding) begin
        if (!it.encoding_is_chunked) raise_error(ERR_NOTIMPL);
        else if (it.has_content_length) raise_error(ERR_BAD);
        else dec_phase = PH_SIZE;
      end else if (it.has_content_length) begin
        if (!it.length_is_valid) begin
          raise_error(ERR_BAD);
        end else if (it.content_length == '0) begin
          dec_phase = PH_COMPLETE;
        end else begin
          dec_left  = it.content_length;
          dec_phase = PH_IDENTITY;
        end
      end else begin
        dec_phase = PH_COMPLETE;
      end
    end else begin
      case (dec_phase)
        PH_IDENTITY: begin
          payload  = 1'b1;
          dec_left = dec_left - 1'b1;
          if (dec_left == '0) dec_phase = PH_COMPLETE;
        end
        PH_SIZE: begin
          if (hx[4]) begin
            if (dec_size[ChunkBits-1:ChunkBits-4] != 4'd0) begin
              raise_error(ERR_BAD);
            end else begin
              dec_size  = {dec_size[ChunkBits-5:0], hx[3:0]};
              dec_digit = 1'b1;
            end
          end else if (c == CHAR_SEMI) begin
            dec_phase = PH_EXT;
          end else if (c == CHAR_CR) begin
            dec_phase = PH_SIZE_LF;
          end else begin
            raise_error(ERR_BAD);
          end
        end
        PH_SIZE_LF: begin
          if (c == CHAR_LF) line_done = 1'b1;
          else raise_error(ERR_BAD);
        end
        PH_EXT: begin
          if (c == CHAR_CR) dec_phase = PH_EXT_LF;
        end
        PH_EXT_LF: begin
          if (c == CHAR_LF) line_done = 1'b1;
          else if (c != CHAR_CR) dec_phase = PH_EXT;
        end
        PH_DATA: begin
          payload  = 1'b1;
          dec_size = dec_size - 1'b1;
          if (dec_size == '0) dec_phase = PH_DATA_CR;
        end
        PH_DATA_CR: begin
          if (c == CHAR_CR) dec_phase = PH_DATA_LF;
          else raise_error(ERR_BAD);
        end
        PH_DATA_LF: begin
          if (c == CHAR_LF) begin
            dec_phase = PH_SIZE;
            dec_size  = '0;
            dec_digit = 1'b0;
          end else begin
            raise_error(ERR_BAD);
          end
        end
        PH_TRAILER: begin
          if (c == CHAR_CR) dec_phase = PH_TRAILER_LF;
          else dec_empty = 1'b0;
        end
        PH_TRAILER_LF: begin
          if (c == CHAR_LF) begin
            if (dec_empty) begin
              dec_phase = PH_COMPLETE;
            end else begin
              dec_empty = 1'b1;
              dec_phase = PH_TRAILER;
            end
          end else begin
            dec_empty = 1'b0;
            if (c != CHAR_CR) dec_phase = PH_TRAILER;
          end
        end
        default: ;
      endcase

      // Close a size line: no digit is an error, zero opens the trailer
      if (line_done) begin
        if (!dec_digit) begin
          raise_error(ERR_BAD);
        end else if (dec_size == '0) begin
          dec_phase = PH_TRAILER;
          dec_empty = 1'b1;
        end else begin
          dec_phase = PH_DATA;
        end
      end
    end

    r.body_valid = payload;
    r.body_byte  = payload ? c : 8'h00;
    if (dec_phase == PH_COMPLETE) r.parse_status = ST_COMPLETE;
    else if (dec_phase == PH_ERROR) r.parse_status = ST_ERROR;
    else r.parse_status = ST_INCOMPLETE;
    r.error_kind = (dec_phase == PH_ERROR) ? dec_error : ERR_NONE;
    return r;
  endfunction

  function automatic in_item_t random_item();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return in_item_t'(r[$bits(in_item_t)-1:0]);
  endfunction

  function automatic in_item_t data_item(input logic [7:0] b);
    in_item_t it;
    it           = random_item();
    it.opcode    = OP_DATA;
    it.data_byte = b;
    return it;
  endfunction

  function automatic in_item_t begin_item(input logic [3:0] hdr,
                                          input logic [LengthBits-1:0] len);
    in_item_t it;
    it        = random_item();
    it.opcode = OP_BEGIN;
    {it.has_transfer_encoding, it.encoding_is_chunked,
     it.has_content_length, it.length_is_valid} = hdr;
    it.content_length = len;
    return it;
  endfunction

  task automatic queue_item(input in_item_t it, input bit counted);
    stim_q.push_back(it);
    hint_q.push_back('0);
    if (counted) generated++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + n;
    return ($urandom_range(1) ? "A" : "a") + n - 8'd10;
  endfunction

  // Line text with no CR ending it; now and then a lone CR inside
  task automatic put_text(input int n);
    logic [7:0] b;
    repeat (n) begin
      if ($urandom_range(7) == 0) begin
        body_text.push_back(CHAR_CR);
        do b = 8'($urandom); while (b == CHAR_CR || b == CHAR_LF);
        body_text.push_back(b);
      end
      do b = 8'($urandom); while (b == CHAR_CR);
      body_text.push_back(b);
    end
  endtask

  // Build the bytes of one chunked body, sometimes damaged
  task automatic build_chunked_body();
    int n;
    int size;
    int idx;
    body_text.delete();
    if ($urandom_range(99) < 5) begin
      n = $urandom_range(9, 11);
      body_text.push_back(hex_char(4'($urandom_range(1, 15))));
      for (int i = 1; i < n; i++) body_text.push_back(hex_char(4'($urandom_range(15))));
      body_text.push_back(CHAR_CR);
      body_text.push_back(CHAR_LF);
    end
    repeat ($urandom_range(3)) begin
      size = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      repeat ($urandom_range(2)) body_text.push_back("0");
      if (size > 15) body_text.push_back(hex_char(4'(size >> 4)));
      body_text.push_back(hex_char(4'(size)));
      if ($urandom_range(3) == 0) begin
        body_text.push_back(CHAR_SEMI);
        put_text($urandom_range(4));
      end
      body_text.push_back(CHAR_CR);
      body_text.push_back(CHAR_LF);
      repeat (size) body_text.push_back(8'($urandom));
      body_text.push_back(CHAR_CR);
      body_text.push_back(CHAR_LF);
    end
    // last chunk, trailer lines, empty line
    repeat ($urandom_range(1, 2)) body_text.push_back("0");
    if ($urandom_range(3) == 0) begin
      body_text.push_back(CHAR_SEMI);
      put_text($urandom_range(4));
    end
    body_text.push_back(CHAR_CR);
    body_text.push_back(CHAR_LF);
    repeat ($urandom_range(2)) begin
      put_text($urandom_range(1, 4));
      body_text.push_back(CHAR_CR);
      body_text.push_back(CHAR_LF);
    end
    body_text.push_back(CHAR_CR);
    body_text.push_back(CHAR_LF);
    // damage one byte: overwrite or drop
    if ($urandom_range(4) == 0) begin
      idx = $urandom_range(body_text.size() - 1);
      if ($urandom_range(1)) body_text[idx] = 8'($urandom);
      else body_text.delete(idx);
    end
  endtask

  task automatic build_stimulus();
    in_item_t it;
    int pick;
    int n;
    logic [LengthBits-1:0] len;
    // walk the directed table
    for (int i = 0; i < PLAN_ROWS; i++) begin
      it        = '0;
      it.opcode = PLAN[i].op;
      {it.has_transfer_encoding, it.encoding_is_chunked,
       it.has_content_length, it.length_is_valid} = PLAN[i].hdr;
      it.content_length = PLAN[i].len;
      it.data_byte      = PLAN[i].b;
      stim_q.push_back(it);
      hint_q.push_back({PLAN[i].typed, PLAN[i].want});
    end
    // random bodies: mostly well formed, the rest headers only and noise
    generated = 0;
    while (generated < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        build_chunked_body();
        queue_item(begin_item({3'b110, 1'($urandom)}, LengthBits'({$urandom, $urandom})), 1);
        foreach (body_text[i]) queue_item(data_item(body_text[i]), 1);
      end else if (pick < 75) begin
        if ($urandom_range(6) == 0) begin
          len = LengthBits'({$urandom, $urandom}) | 1'b1;
          n   = $urandom_range(1, 4);
        end else begin
          len = LengthBits'($urandom_range(1, 6));
          n   = int'(len);
        end
        queue_item(begin_item({1'b0, 1'($urandom), 2'b11}, len), 1);
        repeat (n) queue_item(data_item(8'($urandom)), 1);
      end else if (pick < 90) begin
        len = $urandom_range(1) ? LengthBits'({$urandom, $urandom}) : NOLEN;
        queue_item(begin_item(4'($urandom), len), 1);
      end else begin
        queue_item(begin_item(HDR_CHUNKED, NOLEN), 1);
        repeat ($urandom_range(1, 6)) queue_item(data_item(8'($urandom)), 1);
      end
      // stray bytes after a body are mostly ignored: leave them out of the count
      if (pick < 90 && $urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3)) queue_item(data_item(8'($urandom)), 0);
      end
    end
  endtask

  // Predict on every accepted item, check every accepted result
  always @(posedge clk) begin : watch
    out_item_t want;
    hint_t     hint;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        want = decode_item(in_item);
        hint = hint_q.pop_front();
        decoded_q.push_back(hint.typed ? hint.want : want);
      end
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("result with none due", 64'(out_item), 64'(0));
        end else begin
          want = decoded_q.pop_front();
          if (out_item.body_valid !== want.body_valid)
            report_mismatch("body_valid", 64'(out_item.body_valid), 64'(want.body_valid));
          if (out_item.body_byte !== want.body_byte)
            report_mismatch("body_byte", 64'(out_item.body_byte), 64'(want.body_byte));
          if (out_item.parse_status !== want.parse_status)
            report_mismatch("parse_status", 64'(out_item.parse_status),
                            64'(want.parse_status));
          if (out_item.error_kind !== want.error_kind)
            report_mismatch("error_kind", 64'(out_item.error_kind), 64'(want.error_kind));
        end
      end
    end
  end

  // Reset, send every item, drain and report
  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    build_stimulus();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (stim_q.size() != 0) begin
      while (!calm && $urandom_range(99) < 14) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_item  <= stim_q.pop_front();
      do @(posedge clk); while (in_stall);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (decoded_q.size() != 0)
      report_mismatch("results still due", 64'(decoded_q.size()), 64'(0));
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/hbd_pkg.sv
rtl/hbd_front.sv
rtl/hbd_queue.sv
rtl/hbd_back.sv
rtl/http_body_dechunker.sv
tb/sv/http_body_dechunker_tb.sv
